### src/gbv_pkg.sv
package gbv_pkg;

   // Configuration register indexes (byte address divided by four).
   localparam logic [1:0] REG_CONVERSION_MODE = 2'd0;
   localparam logic [1:0] REG_RECTIFY_MODE    = 2'd1;
   localparam logic [1:0] REG_SCALE_GAIN      = 2'd2;
   localparam logic [1:0] REG_OFFSET_VOLTAGE  = 2'd3;

   // Conversion modes.
   localparam logic [1:0] CONV_UNIPOLAR = 2'd0;
   localparam logic [1:0] CONV_OFFSET   = 2'd1;
   localparam logic [1:0] CONV_SIGN_MAG = 2'd2;

   // Rectify modes.
   localparam logic [1:0] RECT_NONE = 2'd0;
   localparam logic [1:0] RECT_HALF = 2'd1;
   localparam logic [1:0] RECT_FULL = 2'd2;

   // Reset values of the registers.
   localparam logic [15:0] GAIN_RESET = 16'd3277;

   // Thresholds, 2048 steps per volt.
   localparam logic signed [15:0] GATE_THRESHOLD = 16'sd2048;
   localparam logic signed [15:0] SYNC_HIGH      = 16'sd2048;
   localparam logic signed [15:0] SYNC_LOW       = 16'sd0;

   // Full scale is 5 V; the output clamps at 10 V.
   localparam logic signed [16:0] FULL_SCALE = 17'sd10240;
   localparam logic signed [18:0] OUT_LIMIT  = 19'sd20480;

   // Reciprocals for exact floor division of values below 2^21 by 51 and 127.
   localparam int RECIP_SHIFT = 28;
   localparam logic [22:0] RECIP_51  = 23'd5263441;
   localparam logic [22:0] RECIP_127 = 23'd2113666;
   localparam logic [20:0] HALF_51   = 21'd25;
   localparam logic [20:0] HALF_127  = 21'd63;

   // Q14 rounding constant.
   localparam logic [30:0] Q14_HALF = 31'd8192;

   // Schmitt trigger states.
   typedef enum logic [2:0] {
      TRIG_UNKNOWN = 3'b001,
      TRIG_LOW     = 3'b010,
      TRIG_HIGH    = 3'b100
   } trig_state_type;

   // What travels with each word down the pipeline.
   typedef struct packed {
      logic       valid;
      logic       go;
      logic [7:0] code;
   } tag_type;

   // Configuration register contents.
   typedef struct packed {
      logic [1:0]         conversion_mode;
      logic [1:0]         rectify_mode;
      logic signed [15:0] scale_gain;
      logic signed [14:0] offset_voltage;
   } cfg_type;

endpackage

### src/gbv_regs.sv
module gbv_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output gbv_pkg::cfg_type      cfg
);

   gbv_pkg::cfg_type cfg_ff;
   logic [1:0]       reg_index;
   logic             write_en;

   assign reg_index = csr_paddr[3:2];
   assign write_en  = csr_psel && csr_penable && csr_pwrite;

   // Register writes, one register per access.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conversion_mode <= gbv_pkg::CONV_UNIPOLAR;
         cfg_ff.rectify_mode    <= gbv_pkg::RECT_NONE;
         cfg_ff.scale_gain      <= gbv_pkg::GAIN_RESET;
         cfg_ff.offset_voltage  <= '0;
      end else if (write_en) begin
         unique case (reg_index)
            gbv_pkg::REG_CONVERSION_MODE: cfg_ff.conversion_mode <= csr_pwdata[1:0];
            gbv_pkg::REG_RECTIFY_MODE:    cfg_ff.rectify_mode    <= csr_pwdata[1:0];
            gbv_pkg::REG_SCALE_GAIN:      cfg_ff.scale_gain      <= csr_pwdata[15:0];
            gbv_pkg::REG_OFFSET_VOLTAGE:  cfg_ff.offset_voltage  <= csr_pwdata[14:0];
         endcase
      end
   end

   // Read back; signed registers are sign extended.
   always_comb begin
      unique case (reg_index)
         gbv_pkg::REG_CONVERSION_MODE: csr_prdata = {30'd0, cfg_ff.conversion_mode};
         gbv_pkg::REG_RECTIFY_MODE:    csr_prdata = {30'd0, cfg_ff.rectify_mode};
         gbv_pkg::REG_SCALE_GAIN:      csr_prdata = 32'(cfg_ff.scale_gain);
         gbv_pkg::REG_OFFSET_VOLTAGE:  csr_prdata = 32'(cfg_ff.offset_voltage);
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### src/gbv_front.sv
module gbv_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              req_tvalid,
   input  logic [143:0]      req_tdata,
   input  logic [0:0]        req_tuser,
   output gbv_pkg::tag_type  tag
);

   gbv_pkg::trig_state_type trig_ff;
   gbv_pkg::trig_state_type trig_in;
   gbv_pkg::tag_type        tag_ff;
   gbv_pkg::tag_type        tag_in;
   logic signed [15:0]      sync_level;
   logic                    sync_rise;
   logic [7:0]              code;
   logic                    connected;
   logic                    take;

   assign sync_level = req_tdata[143:128];
   assign connected  = req_tuser[0];
   assign take       = advance && req_tvalid;

   // Each gate strictly above 1 V sets its bit of the code.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         code[i] = $signed(req_tdata[16*i +: 16]) > gbv_pkg::GATE_THRESHOLD;
      end
   end

   // Schmitt trigger on the sync voltage; only a rise out of low counts as an edge.
   always_comb begin
      trig_in   = trig_ff;
      sync_rise = 1'b0;
      unique case (trig_ff)
         gbv_pkg::TRIG_LOW: begin
            if (sync_level >= gbv_pkg::SYNC_HIGH) begin
               trig_in   = gbv_pkg::TRIG_HIGH;
               sync_rise = 1'b1;
            end
         end
         gbv_pkg::TRIG_HIGH: begin
            if (sync_level <= gbv_pkg::SYNC_LOW) begin
               trig_in = gbv_pkg::TRIG_LOW;
            end
         end
         default: begin
            if (sync_level >= gbv_pkg::SYNC_HIGH) begin
               trig_in = gbv_pkg::TRIG_HIGH;
            end else if (sync_level <= gbv_pkg::SYNC_LOW) begin
               trig_in = gbv_pkg::TRIG_LOW;
            end else begin
               trig_in = gbv_pkg::TRIG_UNKNOWN;
            end
         end
      endcase
   end

   always_comb begin
      tag_in.valid = req_tvalid;
      tag_in.go    = !connected || sync_rise;
      tag_in.code  = code;
   end

   // The trigger advances only on accepted words that have sync patched.
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff <= gbv_pkg::TRIG_UNKNOWN;
      end else if (take && connected) begin
         trig_ff <= trig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_in;
      end
   end

   assign tag = tag_ff;

endmodule

### src/gbv_convert.sv
module gbv_convert (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  gbv_pkg::tag_type        tag,
   input  logic [1:0]              conversion_mode,
   input  logic [1:0]              rectify_mode,
   output gbv_pkg::tag_type        base_tag,
   output logic signed [14:0]      base
);

   gbv_pkg::tag_type   prod_tag_ff;
   gbv_pkg::tag_type   base_tag_ff;
   logic [43:0]        prod_ff;
   logic [43:0]        prod_in;
   logic [20:0]        numer;
   logic [22:0]        recip;
   logic [15:0]        quot;
   logic signed [16:0] quot_s;
   logic signed [16:0] conv;
   logic signed [16:0] rect;
   logic signed [14:0] base_ff;

   // Numerator plus half the divisor, and the divisor's reciprocal.
   // Unipolar: n*2048/51; offset: n*4096/51 less full scale; sign magnitude: m*10240/127.
   always_comb begin
      unique case (conversion_mode)
         gbv_pkg::CONV_UNIPOLAR: begin
            numer = {2'd0, tag.code, 11'd0} + gbv_pkg::HALF_51;
            recip = gbv_pkg::RECIP_51;
         end
         gbv_pkg::CONV_OFFSET: begin
            numer = {1'b0, tag.code, 12'd0} + gbv_pkg::HALF_51;
            recip = gbv_pkg::RECIP_51;
         end
         gbv_pkg::CONV_SIGN_MAG: begin
            numer = {1'b0, tag.code[6:0], 13'd0} + {3'd0, tag.code[6:0], 11'd0}
                  + gbv_pkg::HALF_127;
            recip = gbv_pkg::RECIP_127;
         end
         default: begin
            numer = '0;
            recip = '0;
         end
      endcase
   end

   assign prod_in = {23'd0, numer} * {21'd0, recip};

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_tag_ff <= '0;
      end else if (advance) begin
         prod_tag_ff <= tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   // Quotient, then the mode's offset or sign.
   assign quot   = prod_ff[gbv_pkg::RECIP_SHIFT +: 16];
   assign quot_s = {1'b0, quot};

   always_comb begin
      unique case (conversion_mode)
         gbv_pkg::CONV_UNIPOLAR: conv = quot_s;
         gbv_pkg::CONV_OFFSET:   conv = quot_s - gbv_pkg::FULL_SCALE;
         gbv_pkg::CONV_SIGN_MAG: conv = prod_tag_ff.code[7] ? -quot_s : quot_s;
         default:                conv = '0;
      endcase
   end

   // Rectification; the unused code leaves the value as it is.
   always_comb begin
      unique case (rectify_mode)
         gbv_pkg::RECT_HALF: rect = conv[16] ? '0 : conv;
         gbv_pkg::RECT_FULL: rect = conv[16] ? -conv : conv;
         default:            rect = conv;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_tag_ff <= '0;
      end else if (advance) begin
         base_tag_ff <= prod_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         base_ff <= rect[14:0];
      end
   end

   assign base_tag = base_tag_ff;
   assign base     = base_ff;

endmodule

### src/gbv_output.sv
module gbv_output (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  gbv_pkg::tag_type     base_tag,
   input  logic signed [14:0]   base,
   input  logic signed [15:0]   scale_gain,
   input  logic signed [14:0]   offset_voltage,
   output logic                 rsp_tvalid,
   output logic [23:0]          rsp_tdata,
   output logic [0:0]           rsp_tuser
);

   gbv_pkg::tag_type   prod_tag_ff;
   logic signed [30:0] prod_ff;
   logic signed [30:0] prod_in;
   logic [30:0]        mag;
   logic [30:0]        mag_rounded;
   logic [16:0]        scaled_mag;
   logic signed [17:0] scaled;
   logic signed [18:0] sum;
   logic signed [18:0] clamped;
   logic               rsp_valid_ff;
   logic               updated_ff;
   logic [15:0]        held_output_ff;
   logic [7:0]         held_code_ff;
   logic               load;

   // Gain multiply.
   assign prod_in = 31'(base) * 31'(scale_gain);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_tag_ff <= '0;
      end else if (advance) begin
         prod_tag_ff <= base_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   // Q14 rounding of the magnitude, ties away from zero, then offset and clamp.
   assign mag         = prod_ff[30] ? 31'(-prod_ff) : 31'(prod_ff);
   assign mag_rounded = mag + gbv_pkg::Q14_HALF;
   assign scaled_mag  = mag_rounded[30:14];
   assign scaled      = prod_ff[30] ? -$signed({1'b0, scaled_mag})
                                    : $signed({1'b0, scaled_mag});
   assign sum         = 19'(scaled) + 19'(offset_voltage);

   always_comb begin
      if (sum > gbv_pkg::OUT_LIMIT) begin
         clamped = gbv_pkg::OUT_LIMIT;
      end else if (sum < -gbv_pkg::OUT_LIMIT) begin
         clamped = -gbv_pkg::OUT_LIMIT;
      end else begin
         clamped = sum;
      end
   end

   assign load = advance && prod_tag_ff.valid;

   // The held value doubles as the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_output_ff <= '0;
         held_code_ff   <= '0;
      end else if (load && prod_tag_ff.go) begin
         held_output_ff <= clamped[15:0];
         held_code_ff   <= prod_tag_ff.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= prod_tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         updated_ff <= prod_tag_ff.go;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {held_code_ff, held_output_ff};
   assign rsp_tuser  = updated_ff;

endmodule

### src/gate_bits_to_voltage_converter_core.sv
// Gate-bits to voltage converter. Each input word carries eight gate voltages and a
// sync voltage (2048 steps per volt) plus a sync-patched flag; each gate above 1 V
// sets one bit of an 8-bit code, which is scaled to a 5 V full-scale value by the
// conversion mode, rectified, multiplied by a Q14 gain and offset, and clamped to
// +/-10 V. With sync patched, the output is recomputed only on a rising edge of the
// sync Schmitt trigger and held otherwise. The datapath is a five-register pipeline:
// one word is accepted per cycle unless stalled, passing the front tag, product, base,
// gain product and result registers. The whole pipeline stalls while a result waits
// to be taken, so req_tready follows rsp_tready then. The user must write registers
// through the APB-style port only while no words are in flight; nothing enforces it.
module gate_bits_to_voltage_converter_core (
   input  logic         clock,
   input  logic         reset,
   // Input word.
   input  logic         req_tvalid,
   output logic         req_tready,
   // [15:0] gate0_voltage, [31:16] gate1_voltage, ... [127:112] gate7_voltage,
   // [143:128] sync_voltage
   input  logic [143:0] req_tdata,
   // [0] sync_connected
   input  logic [0:0]   req_tuser,
   // Result word.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] out_voltage, [23:16] gate_code
   output logic [23:0]  rsp_tdata,
   // [0] updated
   output logic [0:0]   rsp_tuser,
   // Configuration port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   gbv_pkg::cfg_type   cfg;
   gbv_pkg::tag_type   front_tag;
   gbv_pkg::tag_type   base_tag;
   logic signed [14:0] base;
   logic               advance;

   // The pipeline moves whenever the result register is empty or being taken.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign csr_pready = 1'b1;

   gbv_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   gbv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .tag        (front_tag)
   );

   gbv_convert u_convert (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .tag             (front_tag),
      .conversion_mode (cfg.conversion_mode),
      .rectify_mode    (cfg.rectify_mode),
      .base_tag        (base_tag),
      .base            (base)
   );

   gbv_output u_output (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .base_tag       (base_tag),
      .base           (base),
      .scale_gain     (cfg.scale_gain),
      .offset_voltage (cfg.offset_voltage),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser)
   );

endmodule

### src/gbv_checker.sv
module gbv_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [23:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // A stalled result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // While a result is held back, no new input word may enter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while the pipeline is stalled");

   // Delivered voltages stay within the clamp limits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd20480)
                  && ($signed(rsp_tdata[15:0]) >= -16'sd20480))
      else $error("output voltage beyond clamp limits");

   // A word that did not recompute repeats the previous delivered word's payload.
   logic [23:0] last_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_data_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_data_ff <= rsp_tdata;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == last_data_ff)
      else $error("held word differs from the previous result");

endmodule

bind gate_bits_to_voltage_converter_core gbv_checker u_gbv_checker (.*);
